/* hdl/pba_pkg.sv */
// Shared types and codes for the power-of-two bucket allocator.
package pba_pkg;

    // bucket index width, enough for 32 size classes
    localparam int BKT_W = 5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_HEAP = 2'd2;
    localparam logic [1:0] ST_POOL = 2'd3;

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_HSIZE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_POP,
        S_FREE_WR,
        S_GROW,
        S_LIST,
        S_LINK,
        S_TAIL,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       decode;
        logic       pop_rd;
        logic       pop_wr;
        logic       free_wr;
        logic       grow;
        logic       list_step;
        logic       link_wr;
        logic       tail_wr;
        logic       set_status;
        logic [1:0] status_code;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_free;
        logic zero_size;
        logic bkt_over;
        logic head_null;
        logic pool_empty;
        logic overrun;
        logic list_more;
        logic listed;
    } stat_t;

endpackage

/* hdl/pba_ctrl.sv */
// Sequencing state machine of the bucket allocator.
module pba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    output logic           out_load,
    input  pba_pkg::stat_t stat,
    output pba_pkg::cmd_t  cmd
);
    import pba_pkg::*;

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DECODE;
            S_DECODE:   state_next = S_DISPATCH;
            S_DISPATCH: begin
                priority if (!stat.is_free && (stat.zero_size || stat.bkt_over))
                    state_next = S_DONE;
                else if (stat.is_free && (stat.bkt_over || stat.pool_empty))
                    state_next = S_DONE;
                else if (stat.is_free)
                    state_next = S_FREE_WR;
                else if (stat.head_null)
                    state_next = S_GROW;
                else
                    state_next = S_POP;
            end
            S_POP:      state_next = S_DONE;
            S_FREE_WR:  state_next = S_DONE;
            S_GROW:     state_next = (stat.overrun || stat.pool_empty) ? S_DONE : S_LIST;
            S_LIST: begin
                priority if (stat.list_more) state_next = S_LINK;
                else if (stat.listed)        state_next = S_TAIL;
                else                         state_next = S_DONE;
            end
            S_LINK:     state_next = S_LIST;
            S_TAIL:     state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE: cmd.decode = 1'b1;
            S_DISPATCH: begin
                priority if (!stat.is_free && stat.zero_size) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_ZERO;
                end else if (!stat.is_free && stat.bkt_over) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_HEAP;
                end else if (stat.is_free && stat.bkt_over) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                end else if (stat.is_free && stat.pool_empty) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_POOL;
                end else if (!stat.is_free && !stat.head_null) begin
                    cmd.pop_rd = 1'b1;
                end
            end
            S_POP: begin
                cmd.pop_wr      = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
            end
            S_FREE_WR: begin
                cmd.free_wr     = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
            end
            S_GROW: begin
                cmd.grow = 1'b1;
                priority if (stat.overrun) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_HEAP;
                end else if (stat.pool_empty) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_POOL;
                end
            end
            S_LIST: begin
                priority if (stat.list_more) begin
                    cmd.list_step = 1'b1;
                end else if (!stat.listed) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                end
            end
            S_LINK: cmd.link_wr = 1'b1;
            S_TAIL: begin
                cmd.tail_wr     = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
            end
            S_DONE:  out_load = out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/pba_dp.sv */
// Datapath: bucket heads, node pool memories, heap top and result.
module pba_dp #(
    parameter int BUCKET_COUNT = 32,
    parameter int MIN_BUCKET   = 3,
    parameter int EXTENT_BYTES = 8192,
    parameter int NODE_COUNT   = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pba_pkg::cmd_t  cmd,
    output pba_pkg::stat_t stat,
    input  logic           in_kind,
    input  logic [30:0]    in_size,
    input  logic [47:0]    in_addr,
    input  logic [47:0]    base_addr,
    input  logic [31:0]    heap_size,
    output logic [1:0]     status,
    output logic [47:0]    result_addr
);
    import pba_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int NODE_W = $clog2(NODE_COUNT + 1);
    localparam int CNT_W = $clog2(EXTENT_BYTES + 1);
    localparam int BI_W = $clog2(BUCKET_COUNT);
    localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(NODE_COUNT);

    // request and working registers
    logic              kind_reg;
    logic [30:0]       size_reg;
    logic [47:0]       addr_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [1:0]        status_reg;
    logic [47:0]       result_reg;
    logic [47:0]       blk_reg;
    logic [CNT_W-1:0]  chunk_reg;
    logic [NODE_W-1:0] prev_reg;
    logic              listed_reg;

    // allocator state
    logic [NODE_W-1:0] head_reg [BUCKET_COUNT];
    logic [NODE_W-1:0] rec_head_reg;
    logic [NODE_W-1:0] fresh_reg;
    logic [NODE_W-1:0] pool_reg;
    logic [31:0]       top_reg;

    // node memories
    logic [47:0]       addr_mem [NODE_COUNT];
    logic [NODE_W-1:0] link_mem [NODE_COUNT];
    logic [47:0]       addr_rd_reg;
    logic [NODE_W-1:0] link_rd_reg;

    logic [BKT_W-1:0]  bkt_calc;
    logic [30:0]       size_m1;
    logic [NODE_W-1:0] head;
    logic              rec_avail;
    logic [NODE_W-1:0] take_node;
    logic [31:0]       bsize;
    logic              big_block;
    logic [31:0]       space;
    logic [32:0]       grow_sum;
    logic              overrun;
    logic [CNT_W-1:0]  chunks;
    logic [IDX_W-1:0]  link_ra;
    logic              addr_we;
    logic [IDX_W-1:0]  addr_wa;
    logic [47:0]       addr_wd;
    logic              link_we;
    logic [IDX_W-1:0]  link_wa;
    logic [NODE_W-1:0] link_wd;

    // round size up to its bucket
    always_comb begin
        size_m1  = size_reg - 31'd1;
        bkt_calc = '0;
        for (int i = 0; i < 31; i++) begin
            if (size_m1[i]) bkt_calc = BKT_W'(i + 1);
        end
        if (size_reg == 31'd0) bkt_calc = '0;
        if (bkt_calc < BKT_W'(MIN_BUCKET)) bkt_calc = BKT_W'(MIN_BUCKET);
    end

    assign head      = head_reg[bkt_reg[BI_W-1:0]];
    assign rec_avail = (rec_head_reg != NULL_NODE);
    assign take_node = rec_avail ? rec_head_reg : fresh_reg;

    // extent sizing
    assign bsize     = 32'd1 << bkt_reg;
    assign big_block = (bsize >= 32'(EXTENT_BYTES));
    assign space     = big_block ? bsize : 32'(EXTENT_BYTES);
    assign grow_sum  = {1'b0, top_reg} + {1'b0, space};
    assign overrun   = (grow_sum > {1'b0, heap_size});
    assign chunks    = big_block ? CNT_W'(1) : (CNT_W'(EXTENT_BYTES) >> bkt_reg);

    // status to controller
    always_comb begin
        stat.is_free    = (kind_reg == CMD_FREE);
        stat.zero_size  = (size_reg == 31'd0);
        stat.bkt_over   = ({1'b0, bkt_reg} >= (BKT_W + 1)'(BUCKET_COUNT));
        stat.head_null  = (head == NULL_NODE);
        stat.pool_empty = (pool_reg == '0);
        stat.overrun    = overrun;
        stat.list_more  = (chunk_reg != '0) && (pool_reg > NODE_W'(1));
        stat.listed     = listed_reg;
    end

    // memory port selection
    always_comb begin
        link_ra = cmd.pop_rd ? head[IDX_W-1:0] : rec_head_reg[IDX_W-1:0];
        addr_we = cmd.free_wr || cmd.link_wr;
        addr_wa = take_node[IDX_W-1:0];
        addr_wd = cmd.free_wr ? addr_reg : blk_reg;
        link_we = 1'b0;
        link_wa = take_node[IDX_W-1:0];
        link_wd = head;
        priority if (cmd.pop_wr) begin
            link_we = 1'b1;
            link_wa = head[IDX_W-1:0];
            link_wd = rec_head_reg;
        end else if (cmd.free_wr) begin
            link_we = 1'b1;
        end else if (cmd.link_wr && listed_reg) begin
            link_we = 1'b1;
            link_wa = prev_reg[IDX_W-1:0];
            link_wd = take_node;
        end else if (cmd.tail_wr) begin
            link_we = 1'b1;
            link_wa = prev_reg[IDX_W-1:0];
            link_wd = NULL_NODE;
        end
    end

    // node memories, registered reads
    always_ff @(posedge aclk) begin
        if (addr_we) addr_mem[addr_wa] <= addr_wd;
        addr_rd_reg <= addr_mem[head[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        link_rd_reg <= link_mem[link_ra];
    end

    // capture request and working values
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= in_kind;
            size_reg   <= in_size;
            addr_reg   <= in_addr;
            result_reg <= '0;
        end
        if (cmd.decode) bkt_reg <= bkt_calc;
        if (cmd.set_status) status_reg <= cmd.status_code;
        if (cmd.pop_wr) result_reg <= addr_rd_reg;
        if (cmd.grow) begin
            result_reg <= base_addr + 48'(top_reg);
            blk_reg    <= base_addr + 48'(top_reg);
            chunk_reg  <= chunks - CNT_W'(1);
            listed_reg <= 1'b0;
        end
        if (cmd.list_step) blk_reg <= blk_reg + 48'(bsize);
        if (cmd.link_wr) begin
            prev_reg   <= take_node;
            listed_reg <= 1'b1;
            chunk_reg  <= chunk_reg - CNT_W'(1);
        end
    end

    // pool, heads and heap top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUCKET_COUNT; i++) head_reg[i] <= NULL_NODE;
            rec_head_reg <= NULL_NODE;
            fresh_reg    <= '0;
            pool_reg     <= NULL_NODE;
            top_reg      <= '0;
        end else begin
            if (cmd.pop_wr) begin
                head_reg[bkt_reg[BI_W-1:0]] <= link_rd_reg;
                rec_head_reg <= head;
                pool_reg     <= pool_reg + NODE_W'(1);
            end
            if (cmd.free_wr || cmd.link_wr) begin
                if (rec_avail) begin
                    rec_head_reg <= link_rd_reg;
                end else begin
                    fresh_reg <= fresh_reg + NODE_W'(1);
                end
                pool_reg <= pool_reg - NODE_W'(1);
            end
            if (cmd.free_wr || (cmd.link_wr && !listed_reg)) begin
                head_reg[bkt_reg[BI_W-1:0]] <= take_node;
            end
            if (cmd.grow) begin
                top_reg <= overrun ? heap_size : grow_sum[31:0];
            end
        end
    end

    assign status      = status_reg;
    assign result_addr = (status_reg == ST_OK) ? result_reg : '0;

endmodule

/* hdl/pow2_bucket_allocator_top.sv */
// Top level: stream ports, configuration registers and result register.
// Steps: capture, decode, dispatch; zero-size, out-of-range and pool-dry free
// answers come from dispatch, others pop, write a free or refill. A refill links its
// blocks, paced by the registered read of the next free node's link. One request in
// flight: a new request is taken only once the previous result is loaded for output.
// Reset (aresetn, synchronous): all lists empty, full node pool, top zero.
module pow2_bucket_allocator_top #(
    parameter int BUCKET_COUNT = 32,
    parameter int MIN_BUCKET   = 3,
    parameter int EXTENT_BYTES = 8192,
    parameter int NODE_COUNT   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // size[30:0], addr[78:31], zero fill
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[1:0], result_addr[49:2], zero fill
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [47:0] cfg_wdata
);
    import pba_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic        out_load;
    logic        out_free;
    logic [1:0]  status;
    logic [47:0] result_addr;
    logic [47:0] base_reg;
    logic [31:0] hsize_reg;
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            hsize_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BASE:  base_reg  <= cfg_wdata;
                CFG_HSIZE: hsize_reg <= cfg_wdata[31:0];
                default:   ;
            endcase
        end
    end

    pba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    pba_dp #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .MIN_BUCKET   (MIN_BUCKET),
        .EXTENT_BYTES (EXTENT_BYTES),
        .NODE_COUNT   (NODE_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_size     (s_tdata[30:0]),
        .in_addr     (s_tdata[78:31]),
        .base_addr   (base_reg),
        .heap_size   (hsize_reg),
        .status      (status),
        .result_addr (result_addr)
    );

    // result register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_tdata_reg <= {6'd0, result_addr, status};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/pba_checker.sv */
// Checker for the bucket allocator: predicts each request's answer and compares results.
module pba_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [47:0] cfg_wdata,
    output int          errors,
    output int          pending,
    output int          n_checked,
    output int          n_heap,
    output int          n_pool
);
    timeunit 1ns;
    timeprecision 1ps;
    import pba_pkg::*;

    localparam int NODES     = 4096;
    localparam int BUCKETS   = 32;
    localparam int MIN_BKT   = 3;
    localparam int EXTENT    = 8192;
    localparam int NULL_NODE = NODES;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] addr;
    } answer_t;

    answer_t     answers_q[$];

    // shadow allocator state
    logic [47:0] slot_addr [NODES];
    int          slot_next [NODES];
    int          list_head [BUCKETS];
    int          spare_head;
    logic [31:0] top_off;
    logic [47:0] base_reg;
    logic [31:0] limit_reg;

    function automatic int size_class(logic [30:0] size);
        int b;
        b = 0;
        while (b < 40 && (64'd1 << b) < 64'(size)) b++;
        if (b < MIN_BKT) b = MIN_BKT;
        return b;
    endfunction

    function automatic int grab_slot();
        int n;
        n = spare_head;
        if (n >= NULL_NODE) return NULL_NODE;
        spare_head = slot_next[n];
        return n;
    endfunction

    function automatic void drop_slot(int n);
        slot_next[n] = spare_head;
        spare_head = n;
    endfunction

    function automatic answer_t alloc_answer(logic [30:0] size);
        answer_t     a;
        int          b, n, prev, m;
        logic [63:0] bsize, span, start;
        logic [47:0] mem;
        a = '0;
        if (size == 0) begin
            a.status = ST_ZERO;
            return a;
        end
        b = size_class(size);
        if (b >= BUCKETS) begin
            a.status = ST_HEAP;
            return a;
        end
        // pop a listed block when there is one
        n = list_head[b];
        if (n < NULL_NODE) begin
            list_head[b] = slot_next[n];
            a.addr = slot_addr[n];
            drop_slot(n);
            return a;
        end
        // grow the heap by one extent
        bsize = 64'd1 << b;
        span  = (bsize > EXTENT) ? bsize : 64'(EXTENT);
        start = 64'(top_off);
        if (start + span > 64'(limit_reg)) begin
            top_off = limit_reg;
            a.status = ST_HEAP;
            return a;
        end
        top_off = 32'(start + span);
        mem = 48'(64'(base_reg) + start);
        n = grab_slot();
        if (n >= NULL_NODE) begin
            a.status = ST_POOL;
            return a;
        end
        slot_addr[n] = mem;
        slot_next[n] = NULL_NODE;
        list_head[b] = n;
        prev = n;
        for (int i = 1; i < int'(span / bsize); i++) begin
            m = grab_slot();
            if (m >= NULL_NODE) break;
            slot_addr[m] = 48'(64'(mem) + 64'(i) * bsize);
            slot_next[m] = NULL_NODE;
            slot_next[prev] = m;
            prev = m;
        end
        n = list_head[b];
        list_head[b] = slot_next[n];
        a.addr = slot_addr[n];
        drop_slot(n);
        return a;
    endfunction

    function automatic answer_t free_answer(logic [30:0] size, logic [47:0] addr);
        answer_t a;
        int      b, n;
        a = '0;
        b = size_class(size);
        if (b >= BUCKETS) return a;
        n = grab_slot();
        if (n >= NULL_NODE) begin
            a.status = ST_POOL;
            return a;
        end
        slot_addr[n] = addr;
        slot_next[n] = list_head[b];
        list_head[b] = n;
        return a;
    endfunction

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // track config, predict on accepted requests, compare on accepted results
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            answers_q.delete();
            for (int i = 0; i < NODES; i++) begin
                slot_addr[i] = '0;
                slot_next[i] = i + 1;
            end
            for (int i = 0; i < BUCKETS; i++) list_head[i] = NULL_NODE;
            spare_head = 0;
            top_off    = '0;
            base_reg   = '0;
            limit_reg  = '0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_BASE) base_reg = cfg_wdata;
                else limit_reg = cfg_wdata[31:0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_ALLOC) answers_q.push_back(alloc_answer(s_tdata[30:0]));
                else answers_q.push_back(free_answer(s_tdata[30:0], s_tdata[78:31]));
            end
            if (m_tvalid && m_tready) begin
                if (answers_q.size() == 0) begin
                    report("unexpected result", m_tdata[49:2], '0);
                end else begin
                    want = answers_q.pop_front();
                    n_checked++;
                    if (want.status == ST_HEAP) n_heap++;
                    if (want.status == ST_POOL) n_pool++;
                    if (m_tdata[1:0] != want.status)
                        report("status", 48'(m_tdata[1:0]), 48'(want.status));
                    if (m_tdata[49:2] != want.addr)
                        report("result_addr", m_tdata[49:2], want.addr);
                end
            end
        end
        pending = answers_q.size();
    end

    initial begin
        errors = 0;
        pending = 0;
        n_checked = 0;
        n_heap = 0;
        n_pool = 0;
    end

endmodule

/* tb/pow2_bucket_allocator_top_tb.sv */
// Testbench top: clock, reset, request stimulus, config phases and verdict.
module pow2_bucket_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pba_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // size[30:0], addr[78:31], zero fill
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [55:0] m_tdata;        // status[1:0], result_addr[49:2], zero fill
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [47:0] cfg_wdata = '0;

    int errors, pending, n_checked, n_heap, n_pool;
    bit quiet = 1'b0;
    int stall_left = 0;

    always #1 aclk = ~aclk;

    pow2_bucket_allocator_top u_top (.*);

    pba_checker u_chk (.*);

    // stall the result side in short random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // issue one request, with an occasional gap ahead of it
    task automatic send_request(logic cmd, logic [30:0] size, logic [47:0] addr);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, addr, size};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off new requests until every answer is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_region(logic [47:0] base, logic [31:0] limit);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_addr  <= CFG_HSIZE;
        cfg_wdata <= {16'd0, limit};
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [30:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 31'($urandom_range(0, 8));
            7:       return 31'($urandom_range(1, 65536));
            8:       return 31'(1) << $urandom_range(0, 30);
            9:       return 31'($urandom_range(0, 32'h4000_0000));
            default: return 31'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [47:0] pick_addr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    task automatic random_mix(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 6) send_request(CMD_ALLOC, pick_size(), '0);
            else send_request(CMD_FREE, pick_size(), pick_addr());
        end
    endtask

    initial begin
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty region, zero sizes, boundary sizes and addresses
        send_request(CMD_ALLOC, 31'd0, '1);
        send_request(CMD_ALLOC, 31'd8, '0);
        send_request(CMD_FREE, 31'd0, 48'h1234_5678_9abc);
        send_request(CMD_ALLOC, 31'd1, '0);
        send_request(CMD_FREE, 31'h4000_0000, '1);
        send_request(CMD_ALLOC, 31'h4000_0000, '0);
        send_request(CMD_FREE, 31'h7fff_ffff, '1);
        drain();

        // region near the top of the address space so block addresses wrap
        set_region(48'hffff_ffff_f000, 32'hffff_ffff);
        send_request(CMD_ALLOC, 31'd9, '0);
        send_request(CMD_ALLOC, 31'd16, '0);
        send_request(CMD_ALLOC, 31'd8192, '0);
        send_request(CMD_ALLOC, 31'd8193, '0);
        send_request(CMD_ALLOC, 31'h4000_0000, '0);
        send_request(CMD_ALLOC, 31'h2000_0001, '0);
        send_request(CMD_FREE, 31'd3, '0);
        send_request(CMD_ALLOC, 31'd2, '0);
        send_request(CMD_ALLOC, 31'h4000_0000, '0);
        random_mix(400);
        drain();

        // shrink the region below the current top so refills clamp and fail
        set_region(48'({$urandom, $urandom}), 32'd200000);
        send_request(CMD_ALLOC, 31'd100000, '0);
        random_mix(350);
        drain();

        set_region('0, 32'($urandom));
        random_mix(450);
        drain();

        // final stretch with no idling: press the node pool with frees
        set_region('1, 32'hffff_ffff);
        quiet = 1'b1;
        random_mix(250);
        k = 0;
        while (n_pool == 0 && k < 150) begin
            send_request(CMD_FREE, 31'($urandom_range(0, 64)), pick_addr());
            k++;
        end
        send_request(CMD_ALLOC, 31'd8, '0);
        send_request(CMD_FREE, 31'd8, 48'h0000_dead_beef);
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests: %0d heap exhaustions, %0d node pool exhaustions",
                 n_checked, n_heap, n_pool);
        $display("five region settings including empty, maximal and wrapping regions");
        if (errors == 0) begin
            $display("pow2_bucket_allocator_top_tb: PASS");
        end else begin
            $display("pow2_bucket_allocator_top_tb: FAIL");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #40_000_000;
        $display("timeout");
        $display("pow2_bucket_allocator_top_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/pba_pkg.sv
hdl/pba_ctrl.sv
hdl/pba_dp.sv
hdl/pow2_bucket_allocator_top.sv
tb/pba_checker.sv
tb/pow2_bucket_allocator_top_tb.sv
